@@ hdl/cdq_pkg.sv @@
// Shared widths, command and error codes, and controller command bundle for the deque.
package cdq_pkg;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 8;
   localparam int DATA_W  = 32;
   localparam int OCC_W   = 8;
   localparam int ERR_W   = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_READ_INDEX = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd4;

   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load;
   } ctl_type;

endpackage

@@ hdl/cdq_channels.sv @@
// Valid/ready channel interfaces for deque commands and results.
interface cdq_req_if import cdq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] value;
   logic [COUNT_W-1:0] count;

   modport source (output valid, output command, output value, output count, input ready);
   modport sink   (input valid, input command, input value, input count, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data;
   logic [OCC_W-1:0]  occupancy;
   logic              is_empty_flag;
   logic [ERR_W-1:0]  error_code;

   modport source (output valid, output data, output occupancy, output is_empty_flag,
                   output error_code, input ready);
   modport sink   (input valid, input data, input occupancy, input is_empty_flag,
                   input error_code, output ready);
endinterface

@@ hdl/cdq_ctrl.sv @@
// Sequencing state machine: accept, execute, load result register.
module cdq_ctrl import cdq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LOAD
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // Output register can take a new result when empty or draining this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ctl.capture = (state_ff == S_IDLE) && req_valid;
      ctl.exec    = (state_ff == S_EXEC);
      ctl.load    = (state_ff == S_LOAD) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (ctl.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ hdl/cdq_datapath.sv @@
// Element memory, head pointer, element count and result register.
module cdq_datapath import cdq_pkg::*; #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VALUE_W-1:0] req_value,
   input  logic [COUNT_W-1:0] req_count,
   output logic [DATA_W-1:0]  rsp_data,
   output logic [OCC_W-1:0]   rsp_occupancy,
   output logic               rsp_is_empty_flag,
   output logic [ERR_W-1:0]   rsp_error_code
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int SW   = CMPW + 1;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   logic [CMD_W-1:0]      cmd_ff;
   logic [VALUE_W-1:0]    value_ff;
   logic [COUNT_W-1:0]    cnt_ff;
   logic [AW-1:0]         start_ff, start_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  data_sel_ff, data_sel_in;
   logic [ERR_W-1:0]      err_ff, err_in;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [CMPW-1:0]       cnt_ext, count_ext;
   logic                  full, empty;

   logic [DATA_W-1:0]     out_data_ff;
   logic [OCC_W-1:0]      out_occ_ff;
   logic                  out_empty_ff;
   logic [ERR_W-1:0]      out_err_ff;

   // Head-relative offset to slot; offset never exceeds DEPTH when used.
   function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                                input logic [CMPW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
      return sum[AW-1:0];
   endfunction

   assign cnt_ext   = CMPW'(cnt_ff);
   assign count_ext = CMPW'(count_ff);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      start_in    = start_ff;
      count_in    = count_ff;
      err_in      = ERR_OK;
      data_sel_in = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = start_ff;
      rd_addr     = start_ff;
      case (cmd_ff)
         CMD_PUSH_FRONT: begin
            if (full) begin
               err_in = ERR_FULL;
            end else begin
               start_in = (start_ff == '0) ? AW'(DEPTH - 1) : start_ff - 1'b1;
               wr_addr  = start_in;
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               err_in = ERR_FULL;
            end else begin
               wr_addr  = wrap_slot(start_ff, count_ext);
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               err_in = ERR_EMPTY;
            end else begin
               data_sel_in = 1'b1;
               start_in    = wrap_slot(start_ff, CMPW'(1));
               count_in    = count_ff - 1'b1;
            end
         end
         CMD_READ_INDEX: begin
            if (cnt_ext >= count_ext) begin
               err_in = ERR_RANGE;
            end else begin
               rd_addr     = wrap_slot(start_ff, cnt_ext);
               data_sel_in = 1'b1;
            end
         end
         CMD_DROP_FRONT: begin
            if (cnt_ext > count_ext) begin
               err_in = ERR_RANGE;
            end else begin
               start_in = wrap_slot(start_ff, cnt_ext);
               count_in = CW'(count_ext - cnt_ext);
            end
         end
         default: begin
         end
      endcase
   end

   // Hold the accepted command until it executes.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= req_command;
         value_ff <= req_value;
         cnt_ff   <= req_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         count_ff <= '0;
      end else if (ctl.exec) begin
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         err_ff      <= err_in;
         data_sel_ff <= data_sel_in;
         rd_data_ff  <= mem[rd_addr];
         if (wr_en) mem[wr_addr] <= DATA_WIDTH'(value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         out_data_ff  <= data_sel_ff ? DATA_W'(rd_data_ff) : '0;
         out_occ_ff   <= OCC_W'(count_ff);
         out_empty_ff <= empty;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_data          = out_data_ff;
   assign rsp_occupancy     = out_occ_ff;
   assign rsp_is_empty_flag = out_empty_ff;
   assign rsp_error_code    = out_err_ff;

endmodule

@@ hdl/circular_deque_top.sv @@
// Ring-buffer deque: push front/back, pop front, indexed read, drop first n.
//
// Channels: req_chan carries one command (command, value, count) per transfer;
// rsp_chan returns one result per command (data, occupancy, is_empty_flag,
// error_code), in command order. Both use valid/ready.
// Timing: a command is accepted in the idle state, executes in the next cycle
// (pointer and count update plus a memory read, registered, and a write for a
// push), and its result is then loaded into the output register once that
// register is free. A new command is accepted only after the previous one has
// loaded its result; the controller steps through idle, execute and load.
// Stall: the output register holds a result until it is taken; the next
// command may be accepted and executed meanwhile, and waits before loading
// its result until the register is free.
// Reset: head pointer and element count clear; the deque starts empty.
// Memory contents are not cleared; only data from written slots reaches a result.
module circular_deque_top import cdq_pkg::*; #(
   parameter int DEPTH      = 128,
   parameter int DATA_WIDTH = 32
) (
   input logic      clock,
   input logic      reset,
   cdq_req_if.sink  req_chan,
   cdq_rsp_if.source rsp_chan
);

   ctl_type ctl;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctl       (ctl)
   );

   cdq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .req_command       (req_chan.command),
      .req_value         (req_chan.value),
      .req_count         (req_chan.count),
      .rsp_data          (rsp_chan.data),
      .rsp_occupancy     (rsp_chan.occupancy),
      .rsp_is_empty_flag (rsp_chan.is_empty_flag),
      .rsp_error_code    (rsp_chan.error_code)
   );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the ring-buffer deque: directed script, then random traffic.
module tb_top;
   import cdq_pkg::*;

   localparam int DEPTH        = 128;
   localparam int PTR_W        = 7;
   localparam int RANDOM_ITEMS = 880;
   localparam int TAIL_ITEMS   = 150;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_AFTER   = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int LIMIT        = 200000;

   // Command codes the block treats as no-ops.
   localparam logic [CMD_W-1:0] CMD_NOP_LO  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_NOP_MID = 3'd6;
   localparam logic [CMD_W-1:0] CMD_NOP_HI  = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [OCC_W-1:0]  occupancy;
      logic              is_empty_flag;
      logic [ERR_W-1:0]  error_code;
   } deque_result_type;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
      bit                 typed;
      deque_result_type   rsp;
   } script_row_type;

   logic clock;
   logic reset;

   cdq_req_if req_if ();
   cdq_rsp_if rsp_if ();

   circular_deque_top #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_W)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Shadow copy of the deque.
   logic [DATA_W-1:0] shadow_mem [DEPTH];
   logic [PTR_W-1:0]  shadow_head;
   int                shadow_fill;

   deque_result_type pending_rsp [$];
   int               error_count;
   int               rsp_count;
   int               sent_count;
   int               cycle_count;
   bit               quiet_tail;

   function automatic deque_result_type deque_apply(input logic [CMD_W-1:0]   cmd,
                                                    input logic [VALUE_W-1:0] val,
                                                    input logic [COUNT_W-1:0] cnt);
      deque_result_type r;
      logic [PTR_W-1:0] slot;
      r = '0;
      case (cmd)
         CMD_PUSH_FRONT: begin
            if (shadow_fill >= DEPTH) begin
               r.error_code = ERR_FULL;
            end else begin
               shadow_head = shadow_head - 1'b1;
               shadow_mem[shadow_head] = val;
               shadow_fill++;
            end
         end
         CMD_PUSH_BACK: begin
            if (shadow_fill >= DEPTH) begin
               r.error_code = ERR_FULL;
            end else begin
               slot = shadow_head + PTR_W'(shadow_fill);
               shadow_mem[slot] = val;
               shadow_fill++;
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_fill == 0) begin
               r.error_code = ERR_EMPTY;
            end else begin
               r.data = shadow_mem[shadow_head];
               shadow_head = shadow_head + 1'b1;
               shadow_fill--;
            end
         end
         CMD_READ_INDEX: begin
            if (cnt >= shadow_fill) begin
               r.error_code = ERR_RANGE;
            end else begin
               slot = shadow_head + cnt[PTR_W-1:0];
               r.data = shadow_mem[slot];
            end
         end
         CMD_DROP_FRONT: begin
            if (cnt > shadow_fill) begin
               r.error_code = ERR_RANGE;
            end else begin
               // A drop of DEPTH wraps the head back onto itself.
               shadow_head = shadow_head + cnt[PTR_W-1:0];
               shadow_fill = shadow_fill - int'(cnt);
            end
         end
         default: ;
      endcase
      r.occupancy     = OCC_W'(shadow_fill);
      r.is_empty_flag = (shadow_fill == 0);
      return r;
   endfunction

   task automatic send_cmd(input logic [CMD_W-1:0]   cmd,
                           input logic [VALUE_W-1:0] val,
                           input logic [COUNT_W-1:0] cnt,
                           input bit                 typed,
                           input deque_result_type   typed_rsp);
      deque_result_type predicted;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.value   <= val;
      req_if.count   <= cnt;
      do @(posedge clock); while (!req_if.ready);
      predicted = deque_apply(cmd, val, cnt);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      sent_count++;
   endtask

   task automatic run_random(input int n);
      logic [CMD_W-1:0]   cmd;
      logic [COUNT_W-1:0] cnt;
      int                 roll;
      int                 pick;
      bit                 filling;
      filling = 1'b1;
      for (int i = 0; i < n; i++) begin
         quiet_tail = (i >= n - TAIL_ITEMS);
         // Flip the trend once the deque sits at an end for a while.
         if (shadow_fill == DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
         if (shadow_fill == 0 && $urandom_range(0, 5) == 0) filling = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            cmd = CMD_W'($urandom_range(CMD_NOP_LO, CMD_NOP_HI));
         end else if (roll < 18) begin
            cmd = CMD_READ_INDEX;
         end else if (filling) begin
            cmd = (roll < 50) ? CMD_PUSH_BACK : (roll < 80) ? CMD_PUSH_FRONT :
                  (roll < 90) ? CMD_POP_FRONT : CMD_DROP_FRONT;
         end else begin
            cmd = (roll < 33) ? CMD_PUSH_BACK : (roll < 43) ? CMD_PUSH_FRONT :
                  (roll < 75) ? CMD_POP_FRONT : CMD_DROP_FRONT;
         end
         pick = $urandom_range(0, 99);
         if (cmd == CMD_READ_INDEX) begin
            if (pick < 85 && shadow_fill > 0) cnt = COUNT_W'($urandom_range(0, shadow_fill - 1));
            else cnt = COUNT_W'($urandom_range(0, 255));
         end else if (cmd == CMD_DROP_FRONT) begin
            if (pick < 75) cnt = COUNT_W'($urandom_range(0, (shadow_fill < 4) ? shadow_fill : 4));
            else if (pick < 85) cnt = COUNT_W'(shadow_fill);
            else cnt = COUNT_W'($urandom_range(0, 255));
         end else begin
            cnt = COUNT_W'($urandom_range(0, 255));
         end
         send_cmd(cmd, $urandom, cnt, 1'b0, '0);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : cycle_limit
      cycle_count = 0;
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", LIMIT, pending_rsp.size());
      $display("** circular_deque_top: FAILED **");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off to back up the block.
   initial begin : rsp_side
      bit hold_done;
      hold_done      = 1'b0;
      rsp_if.ready  <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!quiet_tail && !hold_done && sent_count >= HOLD_AFTER) begin
            hold_done     = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         deque_result_type want;
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("result %0d arrived with no command outstanding", rsp_count);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.data !== want.data || rsp_if.occupancy !== want.occupancy ||
                rsp_if.is_empty_flag !== want.is_empty_flag ||
                rsp_if.error_code !== want.error_code) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display({"result %0d mismatch: data %h/%h occupancy %0d/%0d ",
                            "empty %0b/%0b error %0d/%0d (expected/actual)"},
                           rsp_count, want.data, rsp_if.data, want.occupancy,
                           rsp_if.occupancy, want.is_empty_flag, rsp_if.is_empty_flag,
                           want.error_code, rsp_if.error_code);
            end
         end
      end
   end

   initial begin : req_side
      script_row_type script [24];
      error_count    = 0;
      rsp_count      = 0;
      sent_count     = 0;
      quiet_tail     = 1'b0;
      shadow_head    = '0;
      shadow_fill    = 0;
      reset         <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.command <= CMD_PUSH_FRONT;
      req_if.value   <= '0;
      req_if.count   <= '0;

      script = '{
         '{CMD_POP_FRONT,  32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ERR_EMPTY}},
         '{CMD_READ_INDEX, 32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ERR_RANGE}},
         '{CMD_DROP_FRONT, 32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ERR_OK}},
         '{CMD_DROP_FRONT, 32'h0,        8'd1,   1'b1, '{32'h0, 8'd0, 1'b1, ERR_RANGE}},
         '{CMD_DROP_FRONT, 32'h0,        8'd128, 1'b1, '{32'h0, 8'd0, 1'b1, ERR_RANGE}},
         '{CMD_NOP_LO,     32'h1234,     8'd3,   1'b1, '{32'h0, 8'd0, 1'b1, ERR_OK}},
         '{CMD_NOP_HI,     32'hFFFFFFFF, 8'd255, 1'b1, '{32'h0, 8'd0, 1'b1, ERR_OK}},
         '{CMD_PUSH_BACK,  32'hFFFFFFFF, 8'd0,   1'b1, '{32'h0, 8'd1, 1'b0, ERR_OK}},
         '{CMD_PUSH_FRONT, 32'h0,        8'd255, 1'b1, '{32'h0, 8'd2, 1'b0, ERR_OK}},
         '{CMD_PUSH_FRONT, 32'h80000001, 8'd0,   1'b0, '0},
         '{CMD_READ_INDEX, 32'h0,        8'd0,   1'b0, '0},
         '{CMD_READ_INDEX, 32'hFFFFFFFF, 8'd2,   1'b0, '0},
         '{CMD_READ_INDEX, 32'h0,        8'd3,   1'b1, '{32'h0, 8'd3, 1'b0, ERR_RANGE}},
         '{CMD_READ_INDEX, 32'h0,        8'd255, 1'b1, '{32'h0, 8'd3, 1'b0, ERR_RANGE}},
         '{CMD_DROP_FRONT, 32'h0,        8'd4,   1'b1, '{32'h0, 8'd3, 1'b0, ERR_RANGE}},
         '{CMD_DROP_FRONT, 32'h0,        8'd2,   1'b0, '0},
         '{CMD_POP_FRONT,  32'h0,        8'd0,   1'b0, '0},
         '{CMD_POP_FRONT,  32'h0,        8'd0,   1'b1, '{32'h0, 8'd0, 1'b1, ERR_EMPTY}},
         '{CMD_PUSH_BACK,  32'h5A5A5A5A, 8'd128, 1'b0, '0},
         '{CMD_NOP_MID,    32'h0,        8'd0,   1'b0, '0},
         '{CMD_DROP_FRONT, 32'h0,        8'd1,   1'b0, '0},
         '{CMD_PUSH_FRONT, 32'hA5A5A5A5, 8'd0,   1'b0, '0},
         '{CMD_DROP_FRONT, 32'h0,        8'd0,   1'b0, '0},
         '{CMD_POP_FRONT,  32'h0,        8'd0,   1'b0, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_cmd(script[i].cmd, script[i].value, script[i].count,
                  script[i].typed, script[i].rsp);
      run_random(RANDOM_ITEMS);
      req_if.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("** circular_deque_top: PASSED **");
      end else begin
         $display("** circular_deque_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/cdq_pkg.sv
hdl/cdq_channels.sv
hdl/cdq_ctrl.sv
hdl/cdq_datapath.sv
hdl/circular_deque_top.sv
tb/tb_top.sv
